### hw/rtl/dirty_range_tracker_core_assert.svh
// Assertion macros for the dirty range tracker core.
`ifndef DIRTY_RANGE_TRACKER_CORE_ASSERT_SVH
`define DIRTY_RANGE_TRACKER_CORE_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define DRT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/drt_pkg.sv
// Shared types and constants for the dirty range tracker.
package drt_pkg;

    localparam int MAX_RANGES = 16;
    localparam int INDEX_BITS = 16;
    localparam int FIRST_W    = INDEX_BITS;
    localparam int COUNT_W    = INDEX_BITS + 1;
    localparam int END_W      = INDEX_BITS + 2;
    localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = {1'b1, {INDEX_BITS{1'b0}}};

    localparam logic [1:0] CMD_MARK     = 2'd0;
    localparam logic [1:0] CMD_TRUNCATE = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;
    localparam logic [1:0] CMD_READ     = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [FIRST_W-1:0] range_first;
        logic [COUNT_W-1:0] range_count;
    } cmd_t;

    typedef struct packed {
        logic [FIRST_W-1:0] out_first;
        logic [COUNT_W-1:0] out_count;
        logic               last_item;
        logic [1:0]         status;
    } rsp_t;

    typedef struct packed {
        logic [FIRST_W-1:0] start;
        logic [COUNT_W-1:0] len;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    typedef struct packed {
        logic             shift;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        entry_t           wr_data;
    } chain_ctl_t;

endpackage

### hw/rtl/drt_cell.sv
// One table cell: holds an entry, loads new data or takes its neighbor's.
module drt_cell (
    input  logic                clk,
    input  drt_pkg::cell_ctl_t  ctl,
    input  drt_pkg::entry_t     nbr,
    input  drt_pkg::entry_t     load_data,
    output drt_pkg::entry_t     q
);

    drt_pkg::entry_t q_reg;
    drt_pkg::entry_t q_next;

    always_comb
    begin
        if (ctl.load)
        begin
            q_next = load_data;
        end
        else if (ctl.shift)
        begin
            q_next = nbr;
        end
        else
        begin
            q_next = q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

### hw/rtl/drt_chain.sv
// Row of table cells shifting toward the head, with an indexed load port.
module drt_chain (
    input  logic                clk,
    input  drt_pkg::chain_ctl_t ctl,
    output drt_pkg::entry_t     head
);

    drt_pkg::entry_t q_arr [drt_pkg::MAX_RANGES];

    genvar i;
    generate
        for (i = 0; i < drt_pkg::MAX_RANGES; i++)
        begin : g_cell
            drt_pkg::entry_t    nbr;
            drt_pkg::cell_ctl_t cctl;

            if (i == drt_pkg::MAX_RANGES - 1)
            begin : g_tail
                assign nbr = q_arr[i];
            end
            else
            begin : g_mid
                assign nbr = q_arr[i+1];
            end

            assign cctl.shift = ctl.shift;
            assign cctl.load  = ctl.wr_en && (ctl.wr_idx == drt_pkg::IDX_W'(i));

            drt_cell u_cell (
                .clk       (clk),
                .ctl       (cctl),
                .nbr       (nbr),
                .load_data (ctl.wr_data),
                .q         (q_arr[i])
            );
        end
    endgenerate

    assign head = q_arr[0];

endmodule

### hw/rtl/dirty_range_tracker_core.sv
// Mark and truncate each walk the stored entries in one pass; clear resets the count.
// Read emits one range per cycle from the head cell while the output is free.
// Commands are taken one at a time; each pass walks the stored entries once.
// The row of cells shifts one entry per pop past a single merge and compare unit.
// Reset: asynchronous, clears control and empties the table; cell contents are kept.
`include "dirty_range_tracker_core_assert.svh"
module dirty_range_tracker_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  drt_pkg::cmd_t   cmd,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output drt_pkg::rsp_t   rsp
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MARK  = 3'd1;
    localparam logic [2:0] ST_TRUNC = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [drt_pkg::CNT_W-1:0]    q_cnt_reg, q_cnt_next;
    logic [drt_pkg::CNT_W-1:0]    idx_reg, idx_next;
    logic [drt_pkg::CNT_W-1:0]    n_reg, n_next;
    logic                         merged_reg, merged_next;
    logic                         cism_reg, cism_next;
    logic [1:0]                   st_reg, st_next;
    logic                         out_valid_reg, out_valid_next;
    drt_pkg::rsp_t                out_reg, out_next;

    logic [drt_pkg::FIRST_W-1:0]  ms_reg, ms_next;
    logic [drt_pkg::END_W-1:0]    me_reg, me_next;
    logic [drt_pkg::FIRST_W-1:0]  lo_reg, lo_next;
    logic [drt_pkg::END_W-1:0]    hi_reg, hi_next;
    logic [drt_pkg::FIRST_W-1:0]  pos_reg, pos_next;
    drt_pkg::entry_t              c_reg, c_next;

    drt_pkg::chain_ctl_t          chain_ctl;
    drt_pkg::entry_t              head;

    logic                         accept;
    logic                         out_free;
    logic                         emit;
    logic                         pop;
    logic                         push;
    logic                         collapse;
    logic                         clr;
    drt_pkg::entry_t              push_data;
    logic [drt_pkg::COUNT_W-1:0]  cnt_sat;
    logic [drt_pkg::END_W-1:0]    head_end;
    logic [drt_pkg::END_W-1:0]    m_len_full;
    logic [drt_pkg::END_W-1:0]    col_len_full;
    logic [drt_pkg::CNT_W-1:0]    q_dec;
    logic [drt_pkg::CNT_W-1:0]    n_dec;
    logic                         ov;

    assign cmd_ready    = (state_reg == ST_IDLE);
    assign accept       = cmd_valid && cmd_ready;
    assign out_free     = !out_valid_reg || rsp_ready;
    assign cnt_sat      = (cmd.range_count > drt_pkg::COUNT_LIMIT) ? drt_pkg::COUNT_LIMIT
                                                                   : cmd.range_count;
    assign head_end     = drt_pkg::END_W'(head.start) + drt_pkg::END_W'(head.len);
    assign m_len_full   = me_reg - drt_pkg::END_W'(ms_reg);
    assign col_len_full = hi_reg - drt_pkg::END_W'(lo_reg);
    assign q_dec        = q_cnt_reg - drt_pkg::CNT_W'(1);
    assign n_dec        = n_reg - drt_pkg::CNT_W'(1);
    assign ov           = (drt_pkg::END_W'(head.start) <= me_reg)
                          && (head_end >= drt_pkg::END_W'(ms_reg));

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        merged_next = merged_reg;
        cism_next   = cism_reg;
        st_next     = st_reg;
        ms_next     = ms_reg;
        me_next     = me_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        pos_next    = pos_reg;
        c_next      = c_reg;
        out_next    = out_reg;
        emit        = 1'b0;
        pop         = 1'b0;
        push        = 1'b0;
        collapse    = 1'b0;
        clr         = 1'b0;
        push_data   = head;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    n_next   = q_cnt_reg;
                    st_next  = drt_pkg::STAT_OK;
                    case (cmd.command)
                        drt_pkg::CMD_MARK:
                        begin
                            if (cnt_sat == '0)
                            begin
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                ms_next     = cmd.range_first;
                                me_next     = drt_pkg::END_W'(cmd.range_first)
                                              + drt_pkg::END_W'(cnt_sat);
                                lo_next     = cmd.range_first;
                                hi_next     = drt_pkg::END_W'(cmd.range_first)
                                              + drt_pkg::END_W'(cnt_sat);
                                merged_next = 1'b0;
                                cism_next   = 1'b1;
                                state_next  = ST_MARK;
                            end
                        end
                        drt_pkg::CMD_TRUNCATE:
                        begin
                            pos_next   = cmd.range_first;
                            state_next = ST_TRUNC;
                        end
                        drt_pkg::CMD_CLEAR:
                        begin
                            clr        = 1'b1;
                            state_next = ST_RESP;
                        end
                        drt_pkg::CMD_READ:
                        begin
                            if (q_cnt_reg == '0)
                            begin
                                st_next    = drt_pkg::STAT_EMPTY;
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_MARK:
            begin
                if (idx_reg != n_reg)
                begin
                    pop      = 1'b1;
                    idx_next = idx_reg + drt_pkg::CNT_W'(1);
                    lo_next  = (head.start < lo_reg) ? head.start : lo_reg;
                    hi_next  = (head_end > hi_reg) ? head_end : hi_reg;
                    if (ov)
                    begin
                        ms_next     = (head.start < ms_reg) ? head.start : ms_reg;
                        me_next     = (head_end > me_reg) ? head_end : me_reg;
                        merged_next = 1'b1;
                    end
                    else if (cism_reg)
                    begin
                        push = 1'b1;
                        if (ms_reg < head.start)
                        begin
                            push_data.start = ms_reg;
                            push_data.len   = m_len_full[drt_pkg::COUNT_W-1:0];
                            c_next          = head;
                            cism_next       = 1'b0;
                        end
                    end
                    else
                    begin
                        push      = 1'b1;
                        push_data = c_reg;
                        c_next    = head;
                    end
                end
                else
                begin
                    state_next = ST_RESP;
                    if (!merged_reg && (n_reg == drt_pkg::CNT_W'(drt_pkg::MAX_RANGES)))
                    begin
                        collapse        = 1'b1;
                        push_data.start = lo_reg;
                        push_data.len   = col_len_full[drt_pkg::COUNT_W-1:0];
                        st_next         = drt_pkg::STAT_OVERFLOW;
                    end
                    else
                    begin
                        push = 1'b1;
                        if (cism_reg)
                        begin
                            push_data.start = ms_reg;
                            push_data.len   = m_len_full[drt_pkg::COUNT_W-1:0];
                        end
                        else
                        begin
                            push_data = c_reg;
                        end
                    end
                end
            end

            ST_TRUNC:
            begin
                if (idx_reg != n_reg)
                begin
                    pop      = 1'b1;
                    idx_next = idx_reg + drt_pkg::CNT_W'(1);
                    if (head.start < pos_reg)
                    begin
                        push = 1'b1;
                        if (head_end > drt_pkg::END_W'(pos_reg))
                        begin
                            push_data.len = drt_pkg::COUNT_W'(pos_reg)
                                            - drt_pkg::COUNT_W'(head.start);
                        end
                    end
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end

            ST_READ:
            begin
                if (out_free)
                begin
                    pop                = 1'b1;
                    push               = 1'b1;
                    emit               = 1'b1;
                    out_next.out_first = head.start;
                    out_next.out_count = head.len;
                    out_next.last_item = (idx_reg == n_dec);
                    out_next.status    = drt_pkg::STAT_OK;
                    idx_next           = idx_reg + drt_pkg::CNT_W'(1);
                    if (idx_reg == n_dec)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    emit               = 1'b1;
                    out_next.out_first = '0;
                    out_next.out_count = '0;
                    out_next.last_item = 1'b1;
                    out_next.status    = st_reg;
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (clr)
        begin
            q_cnt_next = '0;
        end
        else if (collapse)
        begin
            q_cnt_next = drt_pkg::CNT_W'(1);
        end
        else if (push && !pop)
        begin
            q_cnt_next = q_cnt_reg + drt_pkg::CNT_W'(1);
        end
        else if (pop && !push)
        begin
            q_cnt_next = q_dec;
        end
        else
        begin
            q_cnt_next = q_cnt_reg;
        end
    end

    always_comb
    begin
        chain_ctl.shift   = pop;
        chain_ctl.wr_en   = push || collapse;
        chain_ctl.wr_data = push_data;
        if (collapse)
        begin
            chain_ctl.wr_idx = '0;
        end
        else if (pop)
        begin
            chain_ctl.wr_idx = q_dec[drt_pkg::IDX_W-1:0];
        end
        else
        begin
            chain_ctl.wr_idx = q_cnt_reg[drt_pkg::IDX_W-1:0];
        end
    end

    assign out_valid_next = emit ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_reg);

    drt_chain u_chain (
        .clk  (clk),
        .ctl  (chain_ctl),
        .head (head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            q_cnt_reg     <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            merged_reg    <= 1'b0;
            cism_reg      <= 1'b0;
            st_reg        <= drt_pkg::STAT_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            q_cnt_reg     <= q_cnt_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            merged_reg    <= merged_next;
            cism_reg      <= cism_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ms_reg  <= ms_next;
        me_reg  <= me_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        pos_reg <= pos_next;
        c_reg   <= c_next;
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `DRT_ASSERT_ALWAYS(a_cnt_bound, int'(q_cnt_reg) <= drt_pkg::MAX_RANGES, "entry count above capacity")
    `DRT_ASSERT_ALWAYS(a_idx_bound, !((state_reg == ST_MARK) || (state_reg == ST_TRUNC)) || (idx_reg <= n_reg), "pass index beyond entry count")
    `DRT_ASSERT_NEXT(a_clear_empty, accept && (cmd.command == drt_pkg::CMD_CLEAR), q_cnt_reg == '0, "clear left entries")
    `DRT_ASSERT_NEXT(a_read_done, (state_reg == ST_READ) && emit && out_next.last_item, state_reg == ST_IDLE, "read did not finish on last range")

endmodule
